[src/pattern_isomorphism_matcher_assert.svh]
// Assertion macros used by the checker of the matcher.
`ifndef PATTERN_ISOMORPHISM_MATCHER_ASSERT_SVH
`define PATTERN_ISOMORPHISM_MATCHER_ASSERT_SVH

// Checked at every clock edge outside reset.
`define PIM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define PIM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/pim_pkg.sv]
`timescale 1ns / 1ps

package pim_pkg;

  localparam int MaxLen    = 64;
  localparam int Alphabet  = 256;
  localparam int IdxW      = 8;
  localparam int CodeW     = 6;
  localparam int PosW      = 7;
  localparam int PatAw     = 6;
  localparam int WordIdxW  = 16;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);

  localparam logic OpPattern = 1'b0;
  localparam logic OpWord    = 1'b1;

  typedef struct packed {
    logic [WordIdxW-1:0] word_index;
    logic                match;
    logic                too_long;
  } result_t;

endpackage

[src/pim_if.sv]
`timescale 1ns / 1ps

interface pim_text_if;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [pim_pkg::IdxW-1:0] character;
  logic                     last;

  modport source (output valid, operation, character, last, input ready);
  modport sink (input valid, operation, character, last, output ready);
endinterface

interface pim_result_if;
  logic                         valid;
  logic                         ready;
  logic [pim_pkg::WordIdxW-1:0] word_index;
  logic                         match;
  logic                         too_long;

  modport source (output valid, word_index, match, too_long, input ready);
  modport sink (input valid, word_index, match, too_long, output ready);
endinterface

[src/pattern_isomorphism_matcher.sv]
`timescale 1ns / 1ps
// Pattern isomorphism matcher.
// The text channel carries one byte per beat with its operation (pattern or
// word) and a last flag that closes the string. Each string is relabelled by
// order of first occurrence; the pattern's codes are kept, and every word is
// compared against them. The result channel carries one beat per word, on the
// word's last byte: the word index, the match flag and the too-long flag.
// Throughput is one byte per cycle while text ready is high. A result beat is
// offered once the word's last byte has passed the compare stage and been
// written to the result buffer: the code table and the pattern store are
// synchronous memories, read in the accept cycle and compared in the next.
// Seen bits are flip-flops, cleared all at once at each string start.
// Results queue in a four-beat buffer; text ready falls only when that buffer,
// counting a result still in the compare stage, holds more than three beats,
// so a stalled receiver holds up the text channel once four results are held.
// Reset is synchronous: it empties the buffer and the pipeline and leaves no
// pattern loaded, so words report no match until a pattern arrives. Memory
// contents are not cleared.
module pattern_isomorphism_matcher (
  input logic           clk,
  input logic           rst,
  pim_text_if.sink      text,
  pim_result_if.source  result
);

  typedef struct packed {
    logic                         op;
    logic                         last;
    logic                         start;
    logic                         is_new;
    logic [pim_pkg::CodeW-1:0]    new_code;
    logic [pim_pkg::PatAw-1:0]    pos;
    logic                         pos_ok;
    logic                         cmp;
    logic                         mis0;
    logic                         lenmis;
    logic                         overrun;
    logic [pim_pkg::WordIdxW-1:0] index;
  } stage_t;

  logic [pim_pkg::CodeW-1:0] code_mem [pim_pkg::Alphabet];
  logic [pim_pkg::CodeW-1:0] pat_mem [pim_pkg::MaxLen];

  logic [pim_pkg::Alphabet-1:0] seen, seen_next;
  logic                         busy, cur_op;
  logic [pim_pkg::PosW-1:0]     next_code, next_code_next;
  logic [pim_pkg::PosW-1:0]     position, position_next;
  logic [pim_pkg::PosW-1:0]     pattern_length, pattern_length_next;
  logic                         pattern_overrun, pattern_overrun_next;
  logic                         word_overrun, word_overrun_next;
  logic [pim_pkg::WordIdxW-1:0] word_counter, word_counter_next;
  logic                         word_mismatch;

  logic                         accept, start, is_new, pos_ok;
  logic [pim_pkg::IdxW-1:0]     idx;
  logic [pim_pkg::PosW-1:0]     pos_eff, nc_eff, pos_inc;
  stage_t                       s1, s1_next;
  logic                         s1_valid;

  logic [pim_pkg::CodeW-1:0]    code_rd, pat_rd, fwd_code, code1, pat1;
  logic                         fwd, pat_wr, wm_new, push, pop;
  pim_pkg::result_t             res_next;
  pim_pkg::result_t             fifo [pim_pkg::FifoDepth];
  logic [pim_pkg::FifoPtrW-1:0] wr_ptr, rd_ptr;
  logic [pim_pkg::FifoPtrW:0]   count;

  assign accept = text.valid && text.ready;
  assign idx    = text.character;

  always_comb begin
    start   = !busy || (text.operation != cur_op);
    pos_eff = start ? '0 : position;
    nc_eff  = start ? '0 : next_code;
    is_new  = start || !seen[idx];
    pos_ok  = pos_eff < pim_pkg::PosW'(pim_pkg::MaxLen);
    pos_inc = pos_eff + pim_pkg::PosW'(1);

    seen_next      = start ? '0 : seen;
    seen_next[idx] = 1'b1;
    next_code_next = (is_new && nc_eff < pim_pkg::PosW'(pim_pkg::MaxLen)) ?
                     nc_eff + pim_pkg::PosW'(1) : nc_eff;
    position_next  = pos_ok ? pos_inc : pos_eff;

    pattern_length_next  = pattern_length;
    pattern_overrun_next = pattern_overrun;
    word_overrun_next    = start ? 1'b0 : word_overrun;
    word_counter_next    = word_counter;
    if (text.operation == pim_pkg::OpPattern) begin
      if (pos_ok) begin
        pattern_length_next = pos_inc;
      end
      pattern_overrun_next = (start ? 1'b0 : pattern_overrun) | !pos_ok;
      if (start) begin
        word_counter_next = '0;
      end
    end else begin
      word_overrun_next = word_overrun_next | !pos_ok;
      if (text.last) begin
        word_counter_next = word_counter + pim_pkg::WordIdxW'(1);
      end
    end

    s1_next.op       = text.operation;
    s1_next.last     = text.last;
    s1_next.start    = start;
    s1_next.is_new   = is_new;
    s1_next.new_code = nc_eff[pim_pkg::CodeW-1:0];
    s1_next.pos      = pos_eff[pim_pkg::PatAw-1:0];
    s1_next.pos_ok   = pos_ok;
    s1_next.cmp      = pos_ok && (pos_eff < pattern_length);
    s1_next.mis0     = pos_ok && (pos_eff >= pattern_length);
    s1_next.lenmis   = text.last && (position_next != pattern_length);
    s1_next.overrun  = word_overrun_next || pattern_overrun;
    s1_next.index    = word_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      cur_op          <= pim_pkg::OpPattern;
      seen            <= '0;
      next_code       <= '0;
      position        <= '0;
      pattern_length  <= '0;
      pattern_overrun <= 1'b0;
      word_overrun    <= 1'b0;
      word_counter    <= '0;
      s1_valid        <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        busy            <= !text.last;
        cur_op          <= text.operation;
        seen            <= seen_next;
        next_code       <= next_code_next;
        position        <= position_next;
        pattern_length  <= pattern_length_next;
        pattern_overrun <= pattern_overrun_next;
        word_overrun    <= word_overrun_next;
        word_counter    <= word_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_new) begin
      code_mem[idx] <= nc_eff[pim_pkg::CodeW-1:0];
    end
    code_rd <= code_mem[idx];
  end

  assign code1  = s1.is_new ? s1.new_code : code_rd;
  assign pat_wr = s1_valid && (s1.op == pim_pkg::OpPattern) && s1.pos_ok;

  always_ff @(posedge clk) begin
    if (pat_wr) begin
      pat_mem[s1.pos] <= code1;
    end
    pat_rd   <= pat_mem[pos_eff[pim_pkg::PatAw-1:0]];
    fwd      <= pat_wr && (s1.pos == pos_eff[pim_pkg::PatAw-1:0]);
    fwd_code <= code1;
  end

  assign pat1   = fwd ? fwd_code : pat_rd;
  assign wm_new = (s1.start ? 1'b0 : word_mismatch) | s1.mis0 | s1.lenmis |
                  (s1.cmp && (pat1 != code1));
  assign push   = s1_valid && (s1.op == pim_pkg::OpWord) && s1.last;

  always_comb begin
    res_next.word_index = s1.index;
    res_next.match      = !wm_new && !s1.overrun;
    res_next.too_long   = s1.overrun;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_mismatch <= 1'b0;
    end else if (s1_valid && (s1.op == pim_pkg::OpWord)) begin
      word_mismatch <= wm_new;
    end
  end

  assign pop = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + pim_pkg::FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + pim_pkg::FifoPtrW'(1);
      end
      count <= count + (pim_pkg::FifoPtrW+1)'(push) - (pim_pkg::FifoPtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= res_next;
    end
  end

  assign text.ready        = (count + (pim_pkg::FifoPtrW+1)'(push)) <=
                             (pim_pkg::FifoPtrW+1)'(pim_pkg::FifoDepth - 1);
  assign result.valid      = count != '0;
  assign result.word_index = fifo[rd_ptr].word_index;
  assign result.match      = fifo[rd_ptr].match;
  assign result.too_long   = fifo[rd_ptr].too_long;

endmodule

[src/pim_checker.sv]
`timescale 1ns / 1ps
`include "pattern_isomorphism_matcher_assert.svh"

module pim_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         text_valid,
  input logic                         text_ready,
  input logic                         text_operation,
  input logic                         text_last,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic [pim_pkg::WordIdxW-1:0] result_word_index,
  input logic                         result_match,
  input logic                         result_too_long
);

  `PIM_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !result_valid, "Result beat offered straight after reset.")
  `PIM_ASSERT(a_result_held, result_valid && !result_ready |=> result_valid && $stable(result_word_index) && $stable(result_match) && $stable(result_too_long), "Stalled result beat changed.")
  `PIM_ASSERT(a_flags_exclusive, result_valid |-> !(result_match && result_too_long), "Overrun word reported as a match.")
  `PIM_ASSERT(a_result_source, $rose(result_valid) |-> $past(text_valid && text_ready && (text_operation == pim_pkg::OpWord) && text_last, 2), "Result beat without a closing word byte.")
  `PIM_ASSERT(a_stall_reason, !text_ready |-> result_valid, "Text channel stalled with no result waiting.")

endmodule

bind pattern_isomorphism_matcher pim_checker u_pim_checker (
  .clk               (clk),
  .rst               (rst),
  .text_valid        (text.valid),
  .text_ready        (text.ready),
  .text_operation    (text.operation),
  .text_last         (text.last),
  .result_valid      (result.valid),
  .result_ready      (result.ready),
  .result_word_index (result.word_index),
  .result_match      (result.match),
  .result_too_long   (result.too_long)
);

[sim/tb_pattern_isomorphism_matcher.sv]
`timescale 1ns / 1ps

module tb_pattern_isomorphism_matcher;

  typedef logic [7:0] text_q_t[$];

  localparam int HoldCycles   = 300;
  localparam int DrainCycles  = 8;
  localparam int DrainBound   = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pim_text_if   text_ch ();
  pim_result_if result_ch ();

  pattern_isomorphism_matcher u_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  always #5 clk = ~clk;

  int send_idle_pct    = 0;
  int recv_idle_pct    = 0;
  int beats_sent       = 0;
  int verdicts_checked = 0;
  int matches_seen     = 0;
  int overruns_seen    = 0;
  int errors           = 0;

  logic hold_active = 1'b0;
  event hold_start;

  // Relabelling state of the predictor.
  logic                         seen_mirror [pim_pkg::Alphabet];
  logic [8:0]                   code_mirror [pim_pkg::Alphabet];
  logic [8:0]                   next_code_m;
  logic [pim_pkg::PosW-1:0]     position_m;
  logic [8:0]                   pattern_code_m [pim_pkg::MaxLen];
  logic [pim_pkg::PosW-1:0]     pattern_len_m;
  logic                         pattern_over_m;
  logic                         word_miss_m;
  logic                         word_over_m;
  logic [pim_pkg::WordIdxW-1:0] word_count_m;
  logic                         string_open_m;
  logic                         string_op_m;
  pim_pkg::result_t             expected_verdicts [$];

  // Bytes of the pattern as the block currently holds it.
  text_q_t              pattern_sent;
  logic                 pattern_open = 1'b0;
  logic [7:0]           byte_map [pim_pkg::Alphabet];

  initial begin
    for (int k = 0; k < pim_pkg::Alphabet; k++) begin
      seen_mirror[k] = 1'b0;
      code_mirror[k] = '0;
    end
    for (int k = 0; k < pim_pkg::MaxLen; k++) pattern_code_m[k] = '0;
    next_code_m    = '0;
    position_m     = '0;
    pattern_len_m  = '0;
    pattern_over_m = 1'b0;
    word_miss_m    = 1'b0;
    word_over_m    = 1'b0;
    word_count_m   = '0;
    string_open_m  = 1'b0;
    string_op_m    = pim_pkg::OpPattern;
  end

  task automatic relabel_and_compare(input logic op, input logic [7:0] ch, input logic lst);
    int               idx;
    logic [8:0]       code;
    pim_pkg::result_t verdict;
    if (!string_open_m || op != string_op_m) begin
      for (idx = 0; idx < pim_pkg::Alphabet; idx++) seen_mirror[idx] = 1'b0;
      next_code_m = '0;
      position_m  = '0;
      word_miss_m = 1'b0;
      word_over_m = 1'b0;
      if (op == pim_pkg::OpPattern) begin
        pattern_len_m  = '0;
        pattern_over_m = 1'b0;
        word_count_m   = '0;
      end
      string_open_m = 1'b1;
      string_op_m   = op;
    end
    idx = int'(ch) % pim_pkg::Alphabet;
    if (!seen_mirror[idx]) begin
      seen_mirror[idx] = 1'b1;
      code_mirror[idx] = next_code_m;
      if (next_code_m < pim_pkg::Alphabet) next_code_m++;
    end
    code = code_mirror[idx];
    if (op == pim_pkg::OpPattern) begin
      if (position_m < pim_pkg::MaxLen) begin
        pattern_code_m[position_m] = code;
        position_m++;
        pattern_len_m = position_m;
      end else begin
        pattern_over_m = 1'b1;
      end
      if (lst) string_open_m = 1'b0;
    end else begin
      if (position_m < pim_pkg::MaxLen) begin
        if (position_m >= pattern_len_m || pattern_code_m[position_m] != code)
          word_miss_m = 1'b1;
        position_m++;
      end else begin
        word_over_m = 1'b1;
      end
      if (lst) begin
        if (position_m != pattern_len_m) word_miss_m = 1'b1;
        verdict.word_index = word_count_m;
        verdict.match      = ~word_miss_m & ~word_over_m & ~pattern_over_m;
        verdict.too_long   = word_over_m | pattern_over_m;
        expected_verdicts.insert(expected_verdicts.size(), verdict);
        word_count_m++;
        string_open_m = 1'b0;
      end
    end
  endtask

  task automatic send_beat(input logic op, input logic [7:0] ch, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.operation <= op;
    text_ch.character <= ch;
    text_ch.last      <= lst;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    relabel_and_compare(op, ch, lst);
    beats_sent++;
  endtask

  task automatic send_text(input logic op, input text_q_t q, input logic close);
    int i;
    if (op == pim_pkg::OpPattern) begin
      if (!pattern_open) pattern_sent = {};
      foreach (q[k]) pattern_sent.insert(pattern_sent.size(), q[k]);
      pattern_open = !close;
    end else begin
      pattern_open = 1'b0;
    end
    for (i = 0; i < q.size(); i++) send_beat(op, q[i], close && (i == q.size() - 1));
  endtask

  task automatic wait_for_verdicts();
    int guard;
    text_ch.valid <= 1'b0;
    for (guard = 0; guard < DrainBound && expected_verdicts.size() != 0; guard++)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic int draw_length();
    if ($urandom_range(49) == 0)
      return $urandom_range(pim_pkg::MaxLen + 4, pim_pkg::MaxLen - 2);
    return $urandom_range(8, 1);
  endfunction

  task automatic draw_text(input int len, output text_q_t q);
    logic [7:0] letters [8];
    int         n_letters;
    int         spread;
    int         i;
    n_letters = $urandom_range(8, 1);
    spread    = $urandom_range(3);
    for (i = 0; i < n_letters; i++) letters[i] = 8'($urandom_range(255));
    q = {};
    for (i = 0; i < len; i++) begin
      if ($urandom_range(2) < spread) q.insert(q.size(), 8'($urandom_range(255)));
      else q.insert(q.size(), letters[$urandom_range(n_letters - 1)]);
    end
  endtask

  // A word built by a random one-to-one byte mapping of the held pattern.
  task automatic mirror_pattern(output text_q_t q);
    int         i;
    int         j;
    logic [7:0] t;
    for (i = 0; i < pim_pkg::Alphabet; i++) byte_map[i] = 8'(i);
    for (i = pim_pkg::Alphabet - 1; i > 0; i--) begin
      j           = $urandom_range(i);
      t           = byte_map[i];
      byte_map[i] = byte_map[j];
      byte_map[j] = t;
    end
    q = {};
    foreach (pattern_sent[k]) q.insert(q.size(), byte_map[pattern_sent[k]]);
  endtask

  always @(posedge clk) begin
    if (hold_active) result_ch.ready <= 1'b0;
    else result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    forever begin
      @(hold_start);
      hold_active <= 1'b1;
      repeat (HoldCycles) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_verdicts
    pim_pkg::result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual index %0d match %0b",
                 $time, result_ch.word_index, result_ch.match);
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        verdicts_checked++;
        if (result_ch.match) matches_seen++;
        if (result_ch.too_long) overruns_seen++;
        if (result_ch.word_index !== want.word_index) begin
          $display("%0t: word_index expected %0d actual %0d",
                   $time, want.word_index, result_ch.word_index);
          errors++;
        end
        if (result_ch.match !== want.match) begin
          $display("%0t: match expected %0b actual %0b (word %0d)",
                   $time, want.match, result_ch.match, want.word_index);
          errors++;
        end
        if (result_ch.too_long !== want.too_long) begin
          $display("%0t: too_long expected %0b actual %0b (word %0d)",
                   $time, want.too_long, result_ch.too_long, want.word_index);
          errors++;
        end
      end
    end
  end

  task automatic test_no_pattern_yet();
    text_q_t q;
    q = {8'h41, 8'h42};
    send_text(pim_pkg::OpWord, q, 1'b1);
    q = {8'hFF};
    send_text(pim_pkg::OpWord, q, 1'b1);
    wait_for_verdicts();
  endtask

  task automatic test_first_occurrence();
    text_q_t q;
    q = {8'h00, 8'hFF, 8'h80, 8'h00};
    send_text(pim_pkg::OpPattern, q, 1'b1);
    q = {8'h7F, 8'h01, 8'hFE, 8'h7F};
    send_text(pim_pkg::OpWord, q, 1'b1);
    q = {8'h11, 8'h22, 8'h33, 8'h22};
    send_text(pim_pkg::OpWord, q, 1'b1);
    q = {8'h11, 8'h22, 8'h33};
    send_text(pim_pkg::OpWord, q, 1'b1);
    q = {8'h11, 8'h22, 8'h33, 8'h11, 8'h11};
    send_text(pim_pkg::OpWord, q, 1'b1);
    wait_for_verdicts();
  endtask

  task automatic test_abandoned_strings();
    text_q_t q;
    q = {8'h05, 8'h06};
    send_text(pim_pkg::OpPattern, q, 1'b0);
    q = {8'h09, 8'h0A};
    send_text(pim_pkg::OpWord, q, 1'b1);
    q = {8'h01};
    send_text(pim_pkg::OpWord, q, 1'b0);
    q = {8'h03};
    send_text(pim_pkg::OpPattern, q, 1'b1);
    q = {8'hAA};
    send_text(pim_pkg::OpWord, q, 1'b1);
    wait_for_verdicts();
  endtask

  task automatic test_length_limit();
    text_q_t q;
    send_idle_pct = 10;
    recv_idle_pct = 30;
    draw_text(pim_pkg::MaxLen, q);
    send_text(pim_pkg::OpPattern, q, 1'b1);
    mirror_pattern(q);
    send_text(pim_pkg::OpWord, q, 1'b1);
    mirror_pattern(q);
    q.insert(q.size(), 8'($urandom_range(255)));
    send_text(pim_pkg::OpWord, q, 1'b1);
    draw_text(pim_pkg::MaxLen + 1, q);
    send_text(pim_pkg::OpPattern, q, 1'b1);
    mirror_pattern(q);
    send_text(pim_pkg::OpWord, q, 1'b1);
    mirror_pattern(q);
    void'(q.pop_back());
    send_text(pim_pkg::OpWord, q, 1'b1);
    wait_for_verdicts();
  endtask

  // The receiver stalls for a long stretch, so the result buffer fills and the
  // text channel is held up while beats keep being offered.
  task automatic test_result_backpressure();
    text_q_t q;
    int      i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    draw_text(2, q);
    send_text(pim_pkg::OpPattern, q, 1'b1);
    -> hold_start;
    for (i = 0; i < 24; i++) begin
      if (i % 3 == 2) draw_text(2, q);
      else mirror_pattern(q);
      send_text(pim_pkg::OpWord, q, 1'b1);
    end
    wait_for_verdicts();
  endtask

  task automatic run_random_texts(input int beats_target);
    int      first;
    int      kind;
    text_q_t q;
    first = beats_sent;
    while (beats_sent - first < beats_target) begin
      kind = $urandom_range(99);
      if (kind < 10 || pattern_sent.size() == 0) begin
        draw_text(draw_length(), q);
        send_text(pim_pkg::OpPattern, q, 1'b1);
      end else if (kind < 15) begin
        draw_text(draw_length(), q);
        send_text(pim_pkg::OpPattern, q, 1'b0);
        mirror_pattern(q);
        send_text(pim_pkg::OpWord, q, 1'b1);
      end else if (kind < 20) begin
        draw_text(draw_length(), q);
        send_text(pim_pkg::OpWord, q, 1'b0);
        draw_text(draw_length(), q);
        send_text(pim_pkg::OpPattern, q, 1'b1);
      end else if (kind < 65) begin
        mirror_pattern(q);
        send_text(pim_pkg::OpWord, q, 1'b1);
      end else if (kind < 85) begin
        mirror_pattern(q);
        q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
        send_text(pim_pkg::OpWord, q, 1'b1);
      end else begin
        draw_text(draw_length(), q);
        send_text(pim_pkg::OpWord, q, 1'b1);
      end
    end
    wait_for_verdicts();
  endtask

  task automatic test_random_slow_receiver();
    send_idle_pct = 18;
    recv_idle_pct = 86;
    run_random_texts(130);
  endtask

  task automatic test_random_slow_sender();
    send_idle_pct = 86;
    recv_idle_pct = 18;
    run_random_texts(130);
  endtask

  task automatic test_random_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_texts(100);
  endtask

  initial begin
    text_ch.valid     <= 1'b0;
    text_ch.operation <= pim_pkg::OpPattern;
    text_ch.character <= '0;
    text_ch.last      <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_no_pattern_yet();
    test_first_occurrence();
    test_abandoned_strings();
    test_length_limit();
    test_result_backpressure();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_full_rate();

    if (expected_verdicts.size() != 0) begin
      $display("%0t: %0d expected verdicts never arrived, expected 0 actual %0d",
               $time, expected_verdicts.size(), expected_verdicts.size());
      errors++;
    end
    $display("Sent %0d text beats and checked %0d word verdicts (%0d matching, %0d too long).",
             beats_sent, verdicts_checked, matches_seen, overruns_seen);
    $display("Phases: directed strings, length limit, stalled receiver, then random traffic.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[pattern_isomorphism_matcher.f]
+incdir+src
src/pim_pkg.sv
src/pim_if.sv
src/pattern_isomorphism_matcher.sv
src/pim_checker.sv
sim/tb_pattern_isomorphism_matcher.sv
